### hdl/proxy_v2_header_parser_unit_macros.svh
// Assertion helpers for the header parser
`ifndef PROXY_V2_HEADER_PARSER_UNIT_MACROS_SVH
`define PROXY_V2_HEADER_PARSER_UNIT_MACROS_SVH
// a implies b on the same edge
`define PVH_ASSERT_IMP(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("check failed");
// a implies b on the next edge
`define PVH_ASSERT_NXT(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("check failed");
`endif

### hdl/pvh_pkg.sv
`default_nettype none
package pvh_pkg;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [2:0] {
    KIND_SRC_ADDR = 3'd0, KIND_DST_ADDR = 3'd1, KIND_SRC_PORT = 3'd2,
    KIND_DST_PORT = 3'd3, KIND_TLV_TYPE = 3'd4, KIND_TLV_VALUE = 3'd5,
    KIND_FINAL = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_INCOMPLETE = 2'd1, ST_BAD = 2'd2, ST_OVERRUN = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001, PH_FIXED = 7'b0000010, PH_ADDR = 7'b0000100,
    PH_TLVH = 7'b0001000, PH_VALUE = 7'b0010000, PH_SKIP = 7'b0100000,
    PH_DONE = 7'b1000000
  } phase_e;

  // One result beat
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_value;
    logic [15:0] field_offset;
    logic [15:0] tlv_length;
    logic [1:0]  status;
    logic        is_proxy;
    logic        is_tcp;
    logic        is_ipv6;
    logic [16:0] byte_count;
    logic        last;
  } result_t;

  // Up to two results per input beat
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] m;
    case (idx)
      4'd0: m = 8'h0D;
      4'd1: m = 8'h0A;
      4'd2: m = 8'h0D;
      4'd3: m = 8'h0A;
      4'd4: m = 8'h00;
      4'd5: m = 8'h0D;
      4'd6: m = 8'h0A;
      4'd7: m = 8'h51;
      4'd8: m = 8'h55;
      4'd9: m = 8'h49;
      4'd10: m = 8'h54;
      4'd11: m = 8'h0A;
      default: m = 8'h00;
    endcase
    return m;
  endfunction
endpackage
`default_nettype wire

### hdl/pvh_front.sv
`default_nettype none
// Parses one byte per beat, produces an entry of up to two results
module pvh_front import pvh_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       stall_in_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       start_req_i,
  input  wire logic       end_of_data_i,
  output logic            push_o,
  output entry_t          entry_o
);
  phase_e      phase_q, phase_d;
  logic [16:0] rcv_q, rcv_d, cons_q, cons_d;
  logic        magic_q, magic_d, prx_q, prx_d, tcp_q, tcp_d, v6_q, v6_d, ovr_q, ovr_d;
  logic [15:0] clen_q, clen_d, tacc_q, tacc_d, tleft_q, tleft_d;
  logic [7:0]  ttype_q, ttype_d;
  logic [1:0]  tpos_q, tpos_d;

  assign in_stall_o = stall_in_i;
  wire acc = in_valid_i & ~in_stall_o;

  always_comb begin
    phase_e      ph;
    logic [16:0] rc, rcn, total, asz, body;
    logic [7:0]  b, cmd;
    logic [16:0] need;
    logic        fin, any, bad;
    entry_t      e;
    phase_d = phase_q; rcv_d = rcv_q; cons_d = cons_q; magic_d = magic_q;
    prx_d = prx_q; tcp_d = tcp_q; v6_d = v6_q; ovr_d = ovr_q; clen_d = clen_q;
    tacc_d = tacc_q; tleft_d = tleft_q; ttype_d = ttype_q; tpos_d = tpos_q;
    e = '0; ph = phase_q; b = data_byte_i; fin = 1'b0; bad = 1'b0;
    cmd = b & 8'hDF;
    if (start_req_i) begin
      rcv_d = '0; cons_d = '0; magic_d = 1'b1; prx_d = 1'b0; tcp_d = 1'b0;
      v6_d = 1'b0; ovr_d = 1'b0; clen_d = '0; tacc_d = '0; tleft_d = '0;
      ttype_d = '0; tpos_d = '0; ph = PH_FIXED;
    end
    rc = rcv_d; rcn = rc + 17'd1;
    total = 17'd16 + {1'b0, clen_d};
    asz = v6_d ? 17'd16 : 17'd4;
    body = rc - 17'd16;
    need = '0;
    any = !(ph == PH_IDLE || ph == PH_DONE);
    if (any) begin
      rcv_d = rcn;
      case (ph)
        PH_FIXED: begin
          if (rc < 17'd12) begin
            if (b != magic_byte(rc[3:0])) magic_d = 1'b0;
          end else if (rc == 17'd12) begin
            if (!b[5]) magic_d = 1'b0;
            if (cmd == 8'h01) prx_d = 1'b1;
            else if (cmd != 8'h00) magic_d = 1'b0;
          end else if (rc == 17'd13) begin
            if (prx_d) begin
              if (b[3:0] == 4'h1) tcp_d = 1'b1;
              else if (b[3:0] != 4'h2) magic_d = 1'b0;
              if (b[7:4] == 4'h2) v6_d = 1'b1;
              else if (b[7:4] != 4'h1) magic_d = 1'b0;
            end
          end else if (rc == 17'd14) begin
            clen_d = {b, 8'h00};
          end else begin
            clen_d = {clen_d[15:8], b};
            total = 17'd16 + {1'b0, clen_d};
            need = prx_d ? (v6_d ? 17'd36 : 17'd12) : 17'd0;
            if (!magic_d || {1'b0, clen_d} < need) begin
              bad = 1'b1; ph = PH_DONE;
            end else begin
              cons_d = 17'd16; ph = prx_d ? PH_ADDR : PH_TLVH;
            end
          end
        end
        PH_ADDR: begin
          e.v0 = 1'b1; e.r0.data_value = b;
          if (body < asz) begin
            e.r0.kind = KIND_SRC_ADDR; e.r0.field_offset = body[15:0];
          end else if (body < (asz << 1)) begin
            e.r0.kind = KIND_DST_ADDR; e.r0.field_offset = 16'(body - asz);
          end else if (body < (asz << 1) + 17'd2) begin
            e.r0.kind = KIND_SRC_PORT; e.r0.field_offset = 16'(body - (asz << 1));
          end else begin
            e.r0.kind = KIND_DST_PORT;
            e.r0.field_offset = 16'(body - (asz << 1) - 17'd2);
            if (body == (asz << 1) + 17'd3) begin
              cons_d = 17'd20 + (asz << 1); ph = PH_TLVH;
            end
          end
        end
        PH_TLVH: begin
          if (tpos_d == 2'd0) begin
            if (total - rc < 17'd3) ph = PH_SKIP;
            else begin ttype_d = b; tpos_d = 2'd1; end
          end else if (tpos_d == 2'd1) begin
            tacc_d = {b, 8'h00}; tpos_d = 2'd2;
          end else begin
            tacc_d = {tacc_d[15:8], b}; tpos_d = 2'd0;
            if ({1'b0, tacc_d} > total - rcn) begin
              ovr_d = 1'b1; ph = PH_SKIP;
            end else begin
              e.v0 = 1'b1; e.r0.kind = KIND_TLV_TYPE; e.r0.data_value = ttype_d;
              e.r0.tlv_length = tacc_d;
              if (tacc_d == 16'd0) cons_d = cons_d + 17'd3;
              else begin tleft_d = tacc_d; ph = PH_VALUE; end
            end
          end
        end
        PH_VALUE: begin
          e.v0 = 1'b1; e.r0.kind = KIND_TLV_VALUE; e.r0.data_value = b;
          e.r0.field_offset = tacc_d - tleft_d;
          tleft_d = tleft_d - 16'd1;
          if (tleft_d == 16'd0) begin
            cons_d = cons_d + 17'd3 + {1'b0, tacc_d}; ph = PH_TLVH;
          end
        end
        default: ;
      endcase
      if (bad) begin
        fin = 1'b1; e.r1.status = ST_BAD;
      end else if (ph == PH_FIXED) begin
        if (end_of_data_i) begin
          fin = 1'b1; e.r1.status = ST_INCOMPLETE; e.r1.byte_count = 17'd16 - rcn;
          ph = PH_DONE;
        end
      end else if (rcn >= total) begin
        fin = 1'b1; e.r1.status = ovr_d ? ST_OVERRUN : ST_OK;
        e.r1.byte_count = ovr_d ? 17'd0 : cons_d; ph = PH_DONE;
      end else if (end_of_data_i) begin
        fin = 1'b1; e.r1.status = ST_INCOMPLETE; e.r1.byte_count = total - rcn;
        ph = PH_DONE;
      end
      if (fin) begin
        e.v1 = 1'b1; e.r1.kind = KIND_FINAL; e.r1.last = 1'b1;
      end
    end
    // flags reflect state after this byte
    e.r0.is_proxy = prx_d; e.r0.is_tcp = tcp_d; e.r0.is_ipv6 = v6_d;
    e.r1.is_proxy = prx_d; e.r1.is_tcp = tcp_d; e.r1.is_ipv6 = v6_d;
    phase_d = ph;
    entry_o = e;
    push_o = acc & (e.v0 | e.v1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; rcv_q <= '0; cons_q <= '0; magic_q <= 1'b1;
      prx_q <= 1'b0; tcp_q <= 1'b0; v6_q <= 1'b0; ovr_q <= 1'b0; clen_q <= '0;
      tacc_q <= '0; tleft_q <= '0; ttype_q <= '0; tpos_q <= '0;
    end else if (acc) begin
      phase_q <= phase_d; rcv_q <= rcv_d; cons_q <= cons_d; magic_q <= magic_d;
      prx_q <= prx_d; tcp_q <= tcp_d; v6_q <= v6_d; ovr_q <= ovr_d; clen_q <= clen_d;
      tacc_q <= tacc_d; tleft_q <= tleft_d; ttype_q <= ttype_d; tpos_q <= tpos_d;
    end
  end
endmodule
`default_nettype wire

### hdl/pvh_queue.sv
`default_nettype none
// Small FIFO of parsed entries between front and back
module pvh_queue import pvh_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  entry_t      data_i,
  output logic        full_o,
  output logic        empty_o,
  input  wire logic   pop_i,
  output entry_t      data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  entry_t        mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

### hdl/pvh_back.sv
`default_nettype none
// Serializes each entry's one or two results onto the output register
module pvh_back import pvh_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic empty_i,
  input  entry_t    entry_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output result_t   res_o
);
  logic    vld_q, half_q;
  result_t res_q;
  logic    take, two;

  // output register free this cycle
  assign take = !vld_q || !out_stall_i;
  assign two = entry_i.v0 & entry_i.v1;
  assign pop_o = take & !empty_i & (!two | half_q);

  always_ff @(posedge clk_i) begin
    if (take && !empty_i) res_q <= (entry_i.v0 && !half_q) ? entry_i.r0 : entry_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0; half_q <= 1'b0;
    end else if (take) begin
      vld_q <= !empty_i;
      if (!empty_i) half_q <= two & !half_q;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o = res_q;
endmodule
`default_nettype wire

### hdl/proxy_v2_header_parser_unit.sv
// Path: each result passes the combinational parser, the queue and the output register.
// Throughput: one byte per cycle while the queue is not full; a byte yields at most two
//   results, the second drained by the output stage after the first, once it is free.
// Reset: rst_ni async active low; parser goes idle, queue and output empty.
`default_nettype none
module proxy_v2_header_parser_unit import pvh_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        start_req_i,
  input  wire logic        end_of_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       data_value_o,
  output logic [15:0]      field_offset_o,
  output logic [15:0]      tlv_length_o,
  output logic [1:0]       status_o,
  output logic             is_proxy_o,
  output logic             is_tcp_o,
  output logic             is_ipv6_o,
  output logic [16:0]      byte_count_o,
  output logic             last_o
);
  logic    push, full, empty, pop;
  entry_t  ent_in, ent_out;
  result_t res;

  pvh_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .stall_in_i(full), .in_stall_o,
    .data_byte_i, .start_req_i, .end_of_data_i, .push_o(push), .entry_o(ent_in)
  );

  pvh_queue #(.Depth(QDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(ent_in), .full_o(full),
    .empty_o(empty), .pop_i(pop), .data_o(ent_out)
  );

  pvh_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .entry_i(ent_out), .pop_o(pop),
    .out_valid_o, .out_stall_i, .res_o(res)
  );

  assign kind_o = res.kind;
  assign data_value_o = res.data_value;
  assign field_offset_o = res.field_offset;
  assign tlv_length_o = res.tlv_length;
  assign status_o = res.status;
  assign is_proxy_o = res.is_proxy;
  assign is_tcp_o = res.is_tcp;
  assign is_ipv6_o = res.is_ipv6;
  assign byte_count_o = res.byte_count;
  assign last_o = res.last;
endmodule
`default_nettype wire

### hdl/pvh_checker.sv
`default_nettype none
`include "proxy_v2_header_parser_unit_macros.svh"
// Port-level checks on the result channel
module pvh_checker import pvh_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  kind_o,
  input wire logic [1:0]  status_o,
  input wire logic        last_o,
  input wire logic [16:0] byte_count_o
);
  // last marks exactly the status beats
  `PVH_ASSERT_IMP(a_last_kind, clk_i, rst_ni, out_valid_o, last_o == (kind_o == KIND_FINAL))
  // data beats carry no status
  `PVH_ASSERT_IMP(a_data_nostat, clk_i, rst_ni, out_valid_o && !last_o,
    status_o == ST_OK && byte_count_o == 17'd0)
  // bad header reports no count
  `PVH_ASSERT_IMP(a_bad_cnt, clk_i, rst_ni, out_valid_o && last_o && status_o == ST_BAD,
    byte_count_o == 17'd0)
  // stalled beat holds
  `PVH_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(kind_o))
endmodule

bind proxy_v2_header_parser_unit pvh_checker u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .kind_o, .status_o, .last_o,
  .byte_count_o
);
`default_nettype wire

### tb/sv/proxy_v2_header_parser_unit_tb.sv
`default_nettype none
module proxy_v2_header_parser_unit_tb;
  import pvh_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned ItemsPerPhase = 200;
  localparam bit [7:0] Signature [12] = '{8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h00, 8'h0D,
                                         8'h0A, 8'h51, 8'h55, 8'h49, 8'h54, 8'h0A};

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        start_req_i;
  logic        end_of_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  kind_o;
  logic [7:0]  data_value_o;
  logic [15:0] field_offset_o;
  logic [15:0] tlv_length_o;
  logic [1:0]  status_o;
  logic        is_proxy_o;
  logic        is_tcp_o;
  logic        is_ipv6_o;
  logic [16:0] byte_count_o;
  logic        last_o;

  proxy_v2_header_parser_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .data_byte_i(data_byte_i), .start_req_i(start_req_i), .end_of_data_i(end_of_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .kind_o(kind_o), .data_value_o(data_value_o), .field_offset_o(field_offset_o),
    .tlv_length_o(tlv_length_o), .status_o(status_o), .is_proxy_o(is_proxy_o),
    .is_tcp_o(is_tcp_o), .is_ipv6_o(is_ipv6_o), .byte_count_o(byte_count_o),
    .last_o(last_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Parser state mirror
  phase_e      ph;
  bit [16:0]   rcv_cnt;
  bit          hdr_ok;
  bit          px;
  bit          tcp;
  bit          v6;
  bit [15:0]   clen;
  bit [7:0]    tlv_kind;
  bit [15:0]   tlv_len;
  bit [15:0]   val_left;
  bit [1:0]    tlv_pos;
  bit          ovr;
  bit [16:0]   cons_cnt;

  result_t expected_items [$];
  int unsigned mismatches;
  int unsigned parsed_bytes;
  int unsigned headers_sent;
  int unsigned results_seen;
  int unsigned in_idle;
  int unsigned out_idle;
  int unsigned quiet_cycles;

  typedef struct {
    bit [7:0] b;
    bit       st;
    bit       eod;
  } beat_t;
  beat_t byte_q [$];

  typedef struct {
    bit [7:0] b;
    bit       st;
    bit       eod;
    bit       chk;
    status_e  sts;
    int       cnt;
  } dir_row_t;

  // Local header, after a stray byte and an aborted start, then a stray byte
  dir_row_t dir_tab [19] = '{
    '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK, 0},
    '{8'hFF, 1'b1, 1'b1, 1'b1, ST_INCOMPLETE, 15},
    '{8'h0D, 1'b1, 1'b0, 1'b0, ST_OK, 0},
    '{8'h0A, 1'b0, 1'b0, 1'b0, ST_OK, 0},
    '{8'h0D, 1'b0, 1'b0, 1'b0, ST_OK, 0},
    '{8'h0A, 1'b0, 1'b0, 1'b0, ST_OK, 0},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK, 0},
    '{8'h0D, 1'b0, 1'b0, 1'b0, ST_OK, 0},
    '{8'h0A, 1'b0, 1'b0, 1'b0, ST_OK, 0},
    '{8'h51, 1'b0, 1'b0, 1'b0, ST_OK, 0},
    '{8'h55, 1'b0, 1'b0, 1'b0, ST_OK, 0},
    '{8'h49, 1'b0, 1'b0, 1'b0, ST_OK, 0},
    '{8'h54, 1'b0, 1'b0, 1'b0, ST_OK, 0},
    '{8'h0A, 1'b0, 1'b0, 1'b0, ST_OK, 0},
    '{8'h20, 1'b0, 1'b0, 1'b0, ST_OK, 0},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK, 0},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK, 0},
    '{8'h00, 1'b0, 1'b1, 1'b1, ST_OK, 16},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK, 0}
  };

  function automatic void clear_hdr();
    rcv_cnt = '0; hdr_ok = 1'b1; px = 1'b0; tcp = 1'b0; v6 = 1'b0; clen = '0;
    tlv_kind = '0; tlv_len = '0; val_left = '0; tlv_pos = '0; ovr = 1'b0;
    cons_cnt = '0;
  endfunction

  function automatic void push_item(kind_e k, int v, int off, int tl, status_e s,
                                    int cnt, bit lst);
    result_t r;
    r.kind = k;
    r.data_value = v[7:0];
    r.field_offset = off[15:0];
    r.tlv_length = tl[15:0];
    r.status = s;
    r.is_proxy = px;
    r.is_tcp = tcp;
    r.is_ipv6 = v6;
    r.byte_count = cnt[16:0];
    r.last = lst;
    expected_items.insert(expected_items.size(), r);
  endfunction

  // Advance the parser mirror by one byte; returns 0 when the byte is ignored
  function automatic bit parse_hdr_byte(bit [7:0] b, bit st, bit eod);
    int rc;
    int total;
    int asz;
    int body;
    int need;
    bit [7:0] cmd;
    if (st) begin
      clear_hdr();
      ph = PH_FIXED;
    end
    if (ph == PH_IDLE || ph == PH_DONE) return 1'b0;
    rc = rcv_cnt;
    rcv_cnt = 17'(rc + 1);
    total = 16 + int'(clen);
    asz = v6 ? 16 : 4;
    case (ph)
      PH_FIXED: begin
        if (rc < 12) begin
          if (b != Signature[rc]) hdr_ok = 1'b0;
        end else if (rc == 12) begin
          cmd = b & ~8'h20;
          if (!b[5]) hdr_ok = 1'b0;
          if (cmd == 8'h01) px = 1'b1;
          else if (cmd != 8'h00) hdr_ok = 1'b0;
        end else if (rc == 13) begin
          if (px) begin
            if (b[3:0] == 4'h1) tcp = 1'b1;
            else if (b[3:0] != 4'h2) hdr_ok = 1'b0;
            if (b[7:4] == 4'h2) v6 = 1'b1;
            else if (b[7:4] != 4'h1) hdr_ok = 1'b0;
          end
        end else if (rc == 14) begin
          clen = {b, 8'h00};
        end else begin
          clen[7:0] = b;
          total = 16 + int'(clen);
          need = px ? (v6 ? 36 : 12) : 0;
          if (!hdr_ok || int'(clen) < need) begin
            push_item(KIND_FINAL, 0, 0, 0, ST_BAD, 0, 1'b1);
            ph = PH_DONE;
            return 1'b1;
          end
          cons_cnt = 17'd16;
          ph = px ? PH_ADDR : PH_TLVH;
        end
      end
      PH_ADDR: begin
        body = rc - 16;
        if (body < asz) push_item(KIND_SRC_ADDR, b, body, 0, ST_OK, 0, 1'b0);
        else if (body < 2 * asz) push_item(KIND_DST_ADDR, b, body - asz, 0, ST_OK, 0, 1'b0);
        else if (body < 2 * asz + 2) begin
          push_item(KIND_SRC_PORT, b, body - 2 * asz, 0, ST_OK, 0, 1'b0);
        end else begin
          push_item(KIND_DST_PORT, b, body - 2 * asz - 2, 0, ST_OK, 0, 1'b0);
          if (body == 2 * asz + 3) begin
            cons_cnt = 17'(16 + 2 * asz + 4);
            ph = PH_TLVH;
          end
        end
      end
      PH_TLVH: begin
        if (tlv_pos == 2'd0) begin
          // fewer than three bytes left: trailing pad, skipped
          if (total - rc < 3) ph = PH_SKIP;
          else begin
            tlv_kind = b;
            tlv_pos = 2'd1;
          end
        end else if (tlv_pos == 2'd1) begin
          tlv_len = {b, 8'h00};
          tlv_pos = 2'd2;
        end else begin
          tlv_len[7:0] = b;
          tlv_pos = 2'd0;
          if (int'(tlv_len) > total - int'(rcv_cnt)) begin
            ovr = 1'b1;
            ph = PH_SKIP;
          end else begin
            push_item(KIND_TLV_TYPE, tlv_kind, 0, tlv_len, ST_OK, 0, 1'b0);
            if (tlv_len == 16'd0) cons_cnt = cons_cnt + 17'd3;
            else begin
              val_left = tlv_len;
              ph = PH_VALUE;
            end
          end
        end
      end
      PH_VALUE: begin
        push_item(KIND_TLV_VALUE, b, int'(tlv_len) - int'(val_left), 0, ST_OK, 0, 1'b0);
        val_left = val_left - 16'd1;
        if (val_left == 16'd0) begin
          cons_cnt = cons_cnt + 17'd3 + {1'b0, tlv_len};
          ph = PH_TLVH;
        end
      end
      default: ;
    endcase
    // Closing status
    if (ph == PH_FIXED) begin
      if (eod) begin
        push_item(KIND_FINAL, 0, 0, 0, ST_INCOMPLETE, 16 - int'(rcv_cnt), 1'b1);
        ph = PH_DONE;
      end
    end else if (int'(rcv_cnt) >= total) begin
      push_item(KIND_FINAL, 0, 0, 0, ovr ? ST_OVERRUN : ST_OK, ovr ? 0 : int'(cons_cnt),
                1'b1);
      ph = PH_DONE;
    end else if (eod) begin
      push_item(KIND_FINAL, 0, 0, 0, ST_INCOMPLETE, total - int'(rcv_cnt), 1'b1);
      ph = PH_DONE;
    end
    return 1'b1;
  endfunction

  // Build one random header into byte_q
  task automatic gen_header();
    bit [7:0] body [$];
    bit [7:0] full [$];
    beat_t bt;
    int pick;
    bit is_px;
    bit is_v6;
    bit is_tcp;
    int asz;
    int ntlv;
    int len;
    int extra;
    int cl;
    int cut;
    int idx;
    bit eod_last;
    pick = $urandom_range(99);
    is_px = ($urandom_range(3) != 0);
    is_v6 = 1'($urandom_range(1));
    is_tcp = 1'($urandom_range(1));
    asz = is_v6 ? 16 : 4;
    if (is_px) repeat (2 * asz + 4) body.insert(body.size(), 8'($urandom));
    ntlv = $urandom_range(0, 3);
    repeat (ntlv) begin
      len = $urandom_range(0, 5);
      body.insert(body.size(), 8'($urandom));
      body.insert(body.size(), 8'(len >> 8));
      body.insert(body.size(), len[7:0]);
      repeat (len) body.insert(body.size(), 8'($urandom));
    end
    if (pick < 8) begin
      // TLV that claims more than is left
      extra = $urandom_range(0, 3);
      len = $urandom_range(extra + 1, 65535);
      body.insert(body.size(), 8'($urandom));
      body.insert(body.size(), 8'(len >> 8));
      body.insert(body.size(), len[7:0]);
      repeat (extra) body.insert(body.size(), 8'($urandom));
    end else if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) body.insert(body.size(), 8'($urandom));
    end
    cl = body.size();
    if (pick >= 8 && pick < 16 && is_px) cl = $urandom_range(0, 2 * asz + 3);
    if (pick >= 34 && pick < 38) cl = $urandom_range(256, 65535);
    foreach (Signature[i]) full.insert(full.size(), Signature[i]);
    full.insert(full.size(), is_px ? 8'h21 : 8'h20);
    full.insert(full.size(),
                is_px ? {is_v6 ? 4'h2 : 4'h1, is_tcp ? 4'h1 : 4'h2} : 8'($urandom));
    full.insert(full.size(), 8'(cl >> 8));
    full.insert(full.size(), cl[7:0]);
    foreach (body[i]) full.insert(full.size(), body[i]);
    // broken fixed part
    if (pick >= 16 && pick < 24) begin
      idx = $urandom_range(0, 13);
      full[idx] = full[idx] ^ 8'($urandom_range(1, 255));
    end
    cut = full.size();
    eod_last = 1'($urandom_range(1));
    if ((pick >= 24 && pick < 38) || (pick >= 38 && pick < 42)) begin
      cut = $urandom_range(1, full.size() - 1);
      eod_last = (pick < 38);
    end
    for (int i = 0; i < cut; i++) begin
      bt.b = full[i];
      bt.st = (i == 0);
      bt.eod = (i == cut - 1) ? eod_last
                              : ($urandom_range(15) == 0 && pick >= 42 && pick < 50);
      byte_q.insert(byte_q.size(), bt);
    end
    // noise after the header
    if (pick >= 90) begin
      repeat ($urandom_range(1, 3)) begin
        bt.b = 8'($urandom);
        bt.st = 1'b0;
        bt.eod = 1'($urandom_range(1));
        byte_q.insert(byte_q.size(), bt);
      end
    end
    headers_sent++;
  endtask

  // Drive one beat; entered and left just after a falling edge
  task automatic send_beat(beat_t bt, bit chk, status_e sts, int cnt);
    while ($urandom_range(99) < in_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= bt.b;
    start_req_i <= bt.st;
    end_of_data_i <= bt.eod;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (parse_hdr_byte(bt.b, bt.st, bt.eod)) parsed_bytes++;
    if (chk) begin
      expected_items[$].kind = KIND_FINAL;
      expected_items[$].status = sts;
      expected_items[$].byte_count = cnt[16:0];
      expected_items[$].last = 1'b1;
    end
    @(negedge clk_i);
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < out_idle);

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_items.size() == 0) begin
        $error("unexpected result beat, kind %0d", kind_o);
        mismatches++;
      end else begin
        e = expected_items.pop_front();
        check_field("kind", e.kind, kind_o);
        check_field("data_value", e.data_value, data_value_o);
        check_field("field_offset", e.field_offset, field_offset_o);
        check_field("tlv_length", e.tlv_length, tlv_length_o);
        check_field("status", e.status, status_o);
        check_field("is_proxy", e.is_proxy, is_proxy_o);
        check_field("is_tcp", e.is_tcp, is_tcp_o);
        check_field("is_ipv6", e.is_ipv6, is_ipv6_o);
        check_field("byte_count", e.byte_count, byte_count_o);
        check_field("last", e.last, last_o);
      end
    end
  end

  // Watchdog on lack of progress
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Main sequence
  initial begin
    beat_t bt;
    int unsigned target;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    start_req_i = 1'b0;
    end_of_data_i = 1'b0;
    out_stall_i = 1'b0;
    rst_ni = 1'b0;
    mismatches = 0;
    parsed_bytes = 0;
    headers_sent = 0;
    results_seen = 0;
    quiet_cycles = 0;
    in_idle = 20;
    out_idle = 88;
    ph = PH_IDLE;
    clear_hdr();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows
    foreach (dir_tab[i]) begin
      bt = '{dir_tab[i].b, dir_tab[i].st, dir_tab[i].eod};
      send_beat(bt, dir_tab[i].chk, dir_tab[i].sts, dir_tab[i].cnt);
    end

    // Random headers under three idle patterns
    for (int p = 0; p < 3; p++) begin
      in_idle = (p == 0) ? 20 : (p == 1) ? 88 : 0;
      out_idle = (p == 0) ? 88 : (p == 1) ? 20 : 0;
      target = parsed_bytes + ItemsPerPhase;
      while (parsed_bytes < target) begin
        gen_header();
        while (byte_q.size() != 0) send_beat(byte_q.pop_front(), 1'b0, ST_OK, 0);
      end
    end
    in_valid_i <= 1'b0;

    while (expected_items.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Parsed %0d bytes over %0d headers, checked %0d result beats.",
             parsed_bytes, headers_sent, results_seen);
    if (mismatches == 0 && expected_items.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
